// ----- hw/rtl/srecord_line_loader_macros.svh -----
// Assertion macros for the S-record line loader.
`ifndef SRECORD_LINE_LOADER_MACROS_SVH
`define SRECORD_LINE_LOADER_MACROS_SVH
`ifndef SYNTHESIS
`define SRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("srecord_line_loader: assertion failed");
`define SRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srecord_line_loader: implication failed");
`else
`define SRL_ASSERT(lbl, prop)
`define SRL_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/srl_pkg.sv -----
`default_nettype none
package srl_pkg;

  localparam int MAX_RECORD_BYTES_DEF = 64;
  localparam logic [7:0] COUNT_LIMIT = 8'd80;
  localparam logic [8:0] LINE_MIN = 9'd10;
  localparam logic [8:0] LEN_SAT = 9'd511;
  localparam logic [15:0] SAVE_SIZE_RESET = 16'd1024;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_4 = 8'h34;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam int OUT_TDATA_W = 48;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOL = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [1:0] RK_DATA = 2'd0;
  localparam logic [1:0] RK_ACCEPT = 2'd1;
  localparam logic [1:0] RK_ENTRY = 2'd2;
  localparam logic [1:0] RK_ERROR = 2'd3;

  localparam logic [2:0] ERR_FORM = 3'd0;
  localparam logic [2:0] ERR_HEX = 3'd1;
  localparam logic [2:0] ERR_TRUNC = 3'd2;
  localparam logic [2:0] ERR_LONG = 3'd3;
  localparam logic [2:0] ERR_CSUM = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOADING = 2'd1,
    PH_DONE = 2'd2,
    PH_FAILED = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_FAIL,
    OP_RD0,
    OP_CNT,
    OP_CSUM,
    OP_SUM,
    OP_PAD,
    OP_ENTRY,
    OP_DSTART,
    OP_DLOAD,
    OP_ACC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic eol_live;
    logic bad_form;
    logic rd_valid;
    logic too_short;
    logic too_long;
    logic sum_done;
    logic csum_bad;
    logic pad_more;
    logic is_entry;
    logic has_data;
    logic nd_last;
    logic out_free;
  } status_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [2:0] addr_len(input logic [3:0] t);
    logic [2:0] r;
    unique case (t)
      4'd1, 4'd9: r = 3'd2;
      4'd2, 4'd8: r = 3'd3;
      4'd3, 4'd7: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/srl_dp.sv -----
`default_nettype none
module srl_dp #(
  parameter int MAX_BYTES = srl_pkg::MAX_RECORD_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire srl_pkg::cmd_t cmd,
  output srl_pkg::status_t st,
  input wire logic [1:0] in_kind,
  input wire logic [7:0] in_char,
  input wire logic cfg_valid,
  input wire logic [15:0] cfg_data,
  output logic m_tvalid,
  input wire logic m_tready,
  output logic [srl_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [1:0] m_tuser,
  output logic m_tlast
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam logic [7:0] MAX_B = 8'(MAX_BYTES);
  localparam logic [7:0] MAX_IDX = 8'(MAX_BYTES - 1);

  logic [8:0] mem [MAX_BYTES];
  logic [8:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic rd_en;

  logic [8:0] line_len;
  logic len_odd;
  logic [3:0] hi_nib;
  logic hi_ok;
  logic [7:0] type_ch;
  logic [7:0] lead_ch;
  srl_pkg::phase_t phase;
  logic [15:0] save_size;
  logic [7:0] cnt;
  logic [7:0] csum;
  logic [7:0] sum;
  logic [7:0] i;
  logic [7:0] idx;
  logic [7:0] nd;
  logic [31:0] addr;

  logic [31:0] o_addr;
  logic [7:0] o_data;
  logic o_save;
  logic [2:0] o_code;

  logic [3:0] t;
  logic [2:0] alen;
  logic [7:0] b;
  logic [4:0] hx;
  logic take_char;
  logic store_ok;
  logic wr_en;
  logic clr_line;
  logic load;
  logic to_save;

  assign t = type_ch[3:0];
  assign alen = srl_pkg::addr_len(t);
  assign b = 8'((line_len - 9'd2) >> 1);
  assign hx = srl_pkg::hex_decode(in_char);
  assign take_char = (cmd.op == srl_pkg::OP_TAKE) && (in_kind == srl_pkg::KIND_CHAR);
  assign store_ok = (line_len >= 9'd2) && (b < MAX_B);
  assign wr_en = take_char && store_ok && line_len[0];
  assign to_save = (addr[31:16] == 16'd0) && (addr[15:0] < save_size);

  assign load = (cmd.op == srl_pkg::OP_FAIL) || (cmd.op == srl_pkg::OP_ENTRY) ||
                (cmd.op == srl_pkg::OP_DLOAD) || (cmd.op == srl_pkg::OP_ACC);
  assign clr_line = (cmd.op == srl_pkg::OP_FAIL) || (cmd.op == srl_pkg::OP_ENTRY) ||
                    (cmd.op == srl_pkg::OP_ACC) ||
                    ((cmd.op == srl_pkg::OP_TAKE) && (in_kind == srl_pkg::KIND_START)) ||
                    ((cmd.op == srl_pkg::OP_TAKE) && (in_kind == srl_pkg::KIND_EOL) &&
                     !st.eol_live);

  always_comb begin
    rd_en = 1'b1;
    rd_addr = '0;
    unique case (cmd.op)
      srl_pkg::OP_RD0: rd_addr = '0;
      srl_pkg::OP_CNT: rd_addr = rd_q[AW-1:0];
      srl_pkg::OP_CSUM: rd_addr = AW'(1);
      srl_pkg::OP_SUM: rd_addr = AW'(i + 8'd1);
      srl_pkg::OP_DSTART: rd_addr = AW'(8'(alen) + 8'd1);
      srl_pkg::OP_DLOAD: rd_addr = AW'(idx + 8'd1);
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[b[AW-1:0]] <= {hi_ok & hx[4], hi_nib, hx[3:0]};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign st.eol_live = (in_kind == srl_pkg::KIND_EOL) && (phase == srl_pkg::PH_LOADING) &&
                       (line_len != 9'd0);
  assign st.bad_form = (line_len < srl_pkg::LINE_MIN) || len_odd || (lead_ch != srl_pkg::CH_S) ||
                       (type_ch < srl_pkg::CH_DIGIT_0) || (type_ch > srl_pkg::CH_DIGIT_9) ||
                       (type_ch == srl_pkg::CH_DIGIT_4);
  assign st.rd_valid = rd_q[8];
  assign st.too_short = (({2'b00, rd_q[7:0]} << 1) + 10'd4) > {1'b0, line_len};
  assign st.too_long = (rd_q[7:0] > srl_pkg::COUNT_LIMIT) || (rd_q[7:0] > MAX_IDX);
  assign st.sum_done = i >= cnt;
  assign st.csum_bad = (~sum) != csum;
  assign st.pad_more = i <= 8'(alen);
  assign st.is_entry = t >= 4'd7;
  assign st.has_data = (t >= 4'd1) && (t <= 4'd3) && (cnt > (8'(alen) + 8'd1));
  assign st.nd_last = nd == 8'd1;
  assign st.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len <= '0;
      len_odd <= 1'b0;
      hi_nib <= '0;
      type_ch <= '0;
      lead_ch <= '0;
      phase <= srl_pkg::PH_IDLE;
      save_size <= srl_pkg::SAVE_SIZE_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        save_size <= cfg_data;
      end
      if (take_char) begin
        if (line_len == 9'd0) begin
          lead_ch <= in_char;
        end
        if (line_len == 9'd1) begin
          type_ch <= in_char;
        end
        if (store_ok && !line_len[0]) begin
          hi_nib <= hx[3:0];
        end
        len_odd <= ~len_odd;
        if (line_len < srl_pkg::LEN_SAT) begin
          line_len <= line_len + 9'd1;
        end
      end else if (clr_line) begin
        line_len <= '0;
        len_odd <= 1'b0;
      end
      if ((cmd.op == srl_pkg::OP_TAKE) && (in_kind == srl_pkg::KIND_START)) begin
        phase <= srl_pkg::PH_LOADING;
      end else if (cmd.op == srl_pkg::OP_FAIL) begin
        phase <= srl_pkg::PH_FAILED;
      end else if (cmd.op == srl_pkg::OP_ENTRY) begin
        phase <= srl_pkg::PH_DONE;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_char && store_ok && !line_len[0]) begin
      hi_ok <= hx[4];
    end
    unique case (cmd.op)
      srl_pkg::OP_CNT: cnt <= rd_q[7:0];
      srl_pkg::OP_CSUM: begin
        csum <= rd_q[7:0];
        sum <= cnt;
        i <= 8'd1;
        addr <= '0;
      end
      srl_pkg::OP_SUM: begin
        sum <= sum + rd_q[7:0];
        if (i <= 8'(alen)) begin
          addr <= {addr[23:0], rd_q[7:0]};
        end
        i <= i + 8'd1;
      end
      srl_pkg::OP_PAD: begin
        addr <= {addr[23:0], 8'd0};
        i <= i + 8'd1;
      end
      srl_pkg::OP_DSTART: begin
        idx <= 8'(alen) + 8'd1;
        nd <= cnt - 8'd1 - 8'(alen);
      end
      srl_pkg::OP_DLOAD: begin
        addr <= addr + 32'd1;
        idx <= idx + 8'd1;
        nd <= nd - 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      srl_pkg::OP_FAIL: begin
        m_tuser <= srl_pkg::RK_ERROR;
        o_addr <= '0;
        o_data <= '0;
        o_save <= 1'b0;
        o_code <= cmd.code;
        m_tlast <= 1'b1;
      end
      srl_pkg::OP_ENTRY: begin
        m_tuser <= srl_pkg::RK_ENTRY;
        o_addr <= addr;
        o_data <= '0;
        o_save <= 1'b0;
        o_code <= srl_pkg::ERR_FORM;
        m_tlast <= 1'b1;
      end
      srl_pkg::OP_DLOAD: begin
        m_tuser <= srl_pkg::RK_DATA;
        o_addr <= addr;
        o_data <= rd_q[7:0];
        o_save <= to_save;
        o_code <= srl_pkg::ERR_FORM;
        m_tlast <= 1'b0;
      end
      srl_pkg::OP_ACC: begin
        m_tuser <= srl_pkg::RK_ACCEPT;
        o_addr <= '0;
        o_data <= '0;
        o_save <= 1'b0;
        o_code <= srl_pkg::ERR_FORM;
        m_tlast <= 1'b1;
      end
      default: ;
    endcase
  end

  assign m_tdata = {4'd0, o_code, o_save, o_data, o_addr};

endmodule
`default_nettype wire

// ----- hw/rtl/srl_ctrl.sv -----
`default_nettype none
module srl_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire srl_pkg::status_t st,
  output srl_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_FORM = 11'b00000000010,
    S_CNT = 11'b00000000100,
    S_CNTV = 11'b00000001000,
    S_SUM = 11'b00000010000,
    S_CHK = 11'b00000100000,
    S_PAD = 11'b00001000000,
    S_ENTRY = 11'b00010000000,
    S_DSTART = 11'b00100000000,
    S_DLOAD = 11'b01000000000,
    S_ACC = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op = srl_pkg::OP_NONE;
    cmd.code = srl_pkg::ERR_FORM;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = srl_pkg::OP_TAKE;
          if (st.eol_live) begin
            state_next = S_FORM;
          end
        end
      end
      S_FORM: begin
        if (st.bad_form) begin
          cmd.code = srl_pkg::ERR_FORM;
          if (st.out_free) begin
            cmd.op = srl_pkg::OP_FAIL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = srl_pkg::OP_RD0;
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        priority if (!st.rd_valid || st.too_short || st.too_long) begin
          priority if (!st.rd_valid) begin
            cmd.code = srl_pkg::ERR_HEX;
          end else if (st.too_short) begin
            cmd.code = srl_pkg::ERR_TRUNC;
          end else begin
            cmd.code = srl_pkg::ERR_LONG;
          end
          if (st.out_free) begin
            cmd.op = srl_pkg::OP_FAIL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = srl_pkg::OP_CNT;
          state_next = S_CNTV;
        end
      end
      S_CNTV: begin
        if (!st.rd_valid) begin
          cmd.code = srl_pkg::ERR_HEX;
          if (st.out_free) begin
            cmd.op = srl_pkg::OP_FAIL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = srl_pkg::OP_CSUM;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        priority if (st.sum_done) begin
          state_next = S_CHK;
        end else if (!st.rd_valid) begin
          cmd.code = srl_pkg::ERR_HEX;
          if (st.out_free) begin
            cmd.op = srl_pkg::OP_FAIL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = srl_pkg::OP_SUM;
        end
      end
      S_CHK: begin
        if (st.csum_bad) begin
          cmd.code = srl_pkg::ERR_CSUM;
          if (st.out_free) begin
            cmd.op = srl_pkg::OP_FAIL;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        priority if (st.pad_more) begin
          cmd.op = srl_pkg::OP_PAD;
        end else if (st.is_entry) begin
          state_next = S_ENTRY;
        end else if (st.has_data) begin
          state_next = S_DSTART;
        end else begin
          state_next = S_ACC;
        end
      end
      S_ENTRY: begin
        if (st.out_free) begin
          cmd.op = srl_pkg::OP_ENTRY;
          state_next = S_IDLE;
        end
      end
      S_DSTART: begin
        cmd.op = srl_pkg::OP_DSTART;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        if (st.out_free) begin
          cmd.op = srl_pkg::OP_DLOAD;
          if (st.nd_last) begin
            state_next = S_ACC;
          end
        end
      end
      S_ACC: begin
        if (st.out_free) begin
          cmd.op = srl_pkg::OP_ACC;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/srecord_line_loader.sv -----
// S-record line loader. Words on the input stream are line characters
// (s_tuser = 0, character in s_tdata), end-of-line marks (s_tuser = 1) and
// start-of-load marks (s_tuser = 2). Characters and start marks are taken
// while idle. An end-of-line mark during a load, after a non-empty line,
// starts the line check of form, hex digits, byte count and checksum. A
// failed check emits an error word; otherwise the address is padded and an
// entry word, the data writes or, for a record with no data, a lone
// record-accepted word follow. Data writes leave at one word per cycle
// while the output is not stalled, followed by one record-accepted word.
// The final word of each line's results carries m_tlast. The input is not
// ready while a line is being checked or emitted; the record buffer has a
// single read port, which sets the one byte per cycle pace of the check.
// A stalled output holds its word and halts the sequencer in place.
// Reset returns the block to the idle session phase with an empty line and
// the save-area size at 1024; cfg_data writes are taken in any cycle.
`default_nettype none
`include "srecord_line_loader_macros.svh"
module srecord_line_loader #(
  parameter int MAX_RECORD_BYTES = srl_pkg::MAX_RECORD_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  input wire logic [7:0] s_tdata,  // character
  input wire logic [1:0] s_tuser,  // kind
  output logic m_tvalid,
  input wire logic m_tready,
  // address, data_byte, to_save_area, error_code, zero fill
  output logic [srl_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [1:0] m_tuser,  // result_kind
  output logic m_tlast,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [15:0] cfg_data
);

  srl_pkg::cmd_t cmd;
  srl_pkg::status_t st;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign out_load = (cmd.op == srl_pkg::OP_FAIL) || (cmd.op == srl_pkg::OP_ENTRY) ||
                    (cmd.op == srl_pkg::OP_DLOAD) || (cmd.op == srl_pkg::OP_ACC);

  srl_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .st(st),
    .cmd(cmd)
  );

  srl_dp #(
    .MAX_BYTES(MAX_RECORD_BYTES)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .st(st),
    .in_kind(s_tuser),
    .in_char(s_tdata),
    .cfg_valid(cfg_valid),
    .cfg_data(cfg_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  `SRL_ASSERT_IMP(a_last_rule, m_tvalid, m_tlast == (m_tuser != srl_pkg::RK_DATA))
  `SRL_ASSERT_IMP(a_no_overwrite, out_load, !m_tvalid || m_tready)
  `SRL_ASSERT(a_out_while_busy, $rose(m_tvalid) |-> !$past(s_tready))

endmodule
`default_nettype wire
